@@ hdl/gnmc_pkg.sv @@
// ----------------------------------------------------------------------------
// gnmc_pkg
// Shared widths, codes, neighbour offset tables and the controller/datapath
// command and status types of the grid neighbour mark counter.
// ----------------------------------------------------------------------------
package gnmc_pkg;

    localparam int CELL_W    = 10;
    localparam int CFG_W     = 11;
    localparam int IDX_W     = 12;
    localparam int TALLY_W   = 4;
    localparam int NBR_NUM   = 8;
    localparam int K_W       = 3;
    localparam int DIV_STEPS = CELL_W;
    localparam int DIV_CNT_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] OFS_MINUS = 2'd0;
    localparam logic [1:0] OFS_ZERO  = 2'd1;
    localparam logic [1:0] OFS_PLUS  = 2'd2;

    typedef struct packed {
        logic clear_step;
        logic mark_write;
        logic query_load;
        logic div_step;
        logic mask_load;
        logic read_issue;
        logic k_skip;
        logic emit_hit;
        logic emit_none;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic mask_empty;
        logic cur_valid;
        logic cur_last;
        logic slot_free;
    } t_dp_status;

    // row offset of neighbour k, row-major with the centre skipped
    function automatic logic [1:0] nbr_dr(input logic [K_W-1:0] k);
        logic [1:0] r;
        case (k)
            3'd0, 3'd1, 3'd2: r = OFS_MINUS;
            3'd3, 3'd4:       r = OFS_ZERO;
            default:          r = OFS_PLUS;
        endcase
        return r;
    endfunction

    // column offset of neighbour k
    function automatic logic [1:0] nbr_dc(input logic [K_W-1:0] k);
        logic [1:0] r;
        case (k)
            3'd0, 3'd3, 3'd5: r = OFS_MINUS;
            3'd1, 3'd6:       r = OFS_ZERO;
            default:          r = OFS_PLUS;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/gnmc_ram.sv @@
// ----------------------------------------------------------------------------
// gnmc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gnmc_ram #(
    parameter int WIDTH  = 1,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/gnmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// gnmc_ctrl
// Sequencer: store clear after reset, mark writes, division, neighbour scan
// and result hand-off.
// ----------------------------------------------------------------------------
module gnmc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_cmd,
    output logic                  o_in_ready,
    input  gnmc_pkg::t_dp_status  i_status,
    output gnmc_pkg::t_ctrl_cmd   o_ctrl
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MASK  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_NONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_CLEAR: begin
                o_ctrl.clear_step = 1'b1;
                if (i_status.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == gnmc_pkg::CMD_QUERY) begin
                        o_ctrl.query_load = 1'b1;
                        n_state           = ST_DIV;
                    end else begin
                        o_ctrl.mark_write = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_ctrl.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_MASK;
                end
            end
            ST_MASK: begin
                o_ctrl.mask_load = 1'b1;
                n_state          = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.mask_empty) begin
                    n_state = ST_NONE;
                end else if (i_status.cur_valid) begin
                    o_ctrl.read_issue = 1'b1;
                    n_state           = ST_EMIT;
                end else begin
                    o_ctrl.k_skip = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_status.slot_free) begin
                    o_ctrl.emit_hit = 1'b1;
                    n_state         = i_status.cur_last ? ST_IDLE : ST_SCAN;
                end
            end
            ST_NONE: begin
                if (i_status.slot_free) begin
                    o_ctrl.emit_none = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/gnmc_dp.sv @@
// ----------------------------------------------------------------------------
// gnmc_dp
// Datapath: grid size registers, bit-serial divider, neighbour mask, index
// generation, mark store access, running counts and output register.
// ----------------------------------------------------------------------------
module gnmc_dp #(
    parameter int MAX_CELLS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [gnmc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gnmc_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [gnmc_pkg::CELL_W-1:0]          i_cell_index,
    input  logic                                 i_mark_value,
    input  logic                                 i_out_ready,
    input  gnmc_pkg::t_ctrl_cmd                  i_ctrl,
    output gnmc_pkg::t_dp_status                 o_status,
    output logic                                 o_out_valid,
    output logic [gnmc_pkg::CELL_W-1:0]          o_neighbor_index,
    output logic                                 o_neighbor_marked,
    output logic                                 o_has_neighbor,
    output logic [gnmc_pkg::TALLY_W-1:0]         o_tile_count,
    output logic [gnmc_pkg::TALLY_W-1:0]         o_mine_count,
    output logic                                 o_last
);

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CW = gnmc_pkg::CELL_W;
    localparam int IW = gnmc_pkg::IDX_W;
    localparam int TW = gnmc_pkg::TALLY_W;
    localparam int NN = gnmc_pkg::NBR_NUM;
    localparam int KW = gnmc_pkg::K_W;

    logic [gnmc_pkg::CFG_W-1:0]     r_row_count;
    logic [gnmc_pkg::CFG_W-1:0]     r_column_count;
    logic [AW-1:0]                  r_clr_addr;
    logic [CW-1:0]                  r_cell;
    logic [CW-1:0]                  r_quo;
    logic [gnmc_pkg::CFG_W-1:0]     r_rem;
    logic [gnmc_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [NN-1:0]                  r_mask;
    logic [KW-1:0]                  r_k;
    logic                           r_rd_in_range;
    logic                           r_rd_last;
    logic [CW-1:0]                  r_nbr_idx;
    logic [TW-1:0]                  r_tiles;
    logic [TW-1:0]                  r_mines;
    logic                           r_out_valid;
    logic [CW-1:0]                  r_out_index;
    logic                           r_out_marked;
    logic                           r_out_has;
    logic [TW-1:0]                  r_out_tiles;
    logic [TW-1:0]                  r_out_mines;
    logic                           r_out_last;

    logic [IW-1:0]  w_div_trial;
    logic           w_div_fit;
    logic [IW-1:0]  w_row;
    logic [IW-1:0]  w_col;
    logic [IW-1:0]  w_rc;
    logic [IW-1:0]  w_cc;
    logic [2:0]     w_row_ok;
    logic [2:0]     w_col_ok;
    logic [NN-1:0]  w_mask;
    logic [IW-1:0]  w_base;
    logic [IW-1:0]  w_idx;
    logic [NN-1:0]  w_above;
    logic           w_wr_en;
    logic [AW-1:0]  w_wr_addr;
    logic           w_wr_data;
    logic           w_rd_data;
    logic           w_mark;
    logic           w_slot_free;

    // divider trial subtract
    assign w_div_trial = {r_rem, r_quo[CW-1]};
    assign w_div_fit   = (w_div_trial >= {1'b0, r_column_count});

    // neighbour mask from row = quotient, column = remainder
    assign w_row = {2'b00, r_quo};
    assign w_col = {1'b0, r_rem};
    assign w_rc  = {1'b0, r_row_count};
    assign w_cc  = {1'b0, r_column_count};

    assign w_row_ok[0] = (r_quo != '0) && ((w_row - 1'b1) < w_rc);
    assign w_row_ok[1] = (w_row < w_rc);
    assign w_row_ok[2] = ((w_row + 1'b1) < w_rc);
    assign w_col_ok[0] = (r_rem != '0) && ((w_col - 1'b1) < w_cc);
    assign w_col_ok[1] = (w_col < w_cc);
    assign w_col_ok[2] = ((w_col + 1'b1) < w_cc);

    always_comb begin
        for (int k = 0; k < NN; k++) begin
            w_mask[k] = w_row_ok[gnmc_pkg::nbr_dr(KW'(k))] &
                        w_col_ok[gnmc_pkg::nbr_dc(KW'(k))];
        end
    end

    // linear index of neighbour k: cell +/- columns +/- 1
    always_comb begin
        case (gnmc_pkg::nbr_dr(r_k))
            gnmc_pkg::OFS_MINUS: w_base = {2'b00, r_cell} - w_cc;
            gnmc_pkg::OFS_PLUS:  w_base = {2'b00, r_cell} + w_cc;
            default:             w_base = {2'b00, r_cell};
        endcase
        case (gnmc_pkg::nbr_dc(r_k))
            gnmc_pkg::OFS_MINUS: w_idx = w_base - 1'b1;
            gnmc_pkg::OFS_PLUS:  w_idx = w_base + 1'b1;
            default:             w_idx = w_base;
        endcase
    end

    assign w_above = (r_mask >> r_k) >> 1;

    // mark store port muxing
    assign w_wr_en   = i_ctrl.clear_step |
                       (i_ctrl.mark_write & (32'(i_cell_index) < 32'(MAX_CELLS)));
    assign w_wr_addr = i_ctrl.clear_step ? r_clr_addr : AW'(i_cell_index);
    assign w_wr_data = i_ctrl.clear_step ? 1'b0 : i_mark_value;

    gnmc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CELLS),
        .ADDR_W(AW)
    ) u_mark_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (i_ctrl.read_issue),
        .i_rd_addr(AW'(w_idx)),
        .o_rd_data(w_rd_data)
    );

    assign w_mark      = w_rd_data & r_rd_in_range;
    assign w_slot_free = !r_out_valid || i_out_ready;

    assign o_status.clear_done = (r_clr_addr == AW'(MAX_CELLS - 1));
    assign o_status.div_done   = (r_div_cnt == gnmc_pkg::DIV_CNT_W'(gnmc_pkg::DIV_STEPS - 1));
    assign o_status.mask_empty = (r_mask == '0);
    assign o_status.cur_valid  = r_mask[r_k];
    assign o_status.cur_last   = r_rd_last;
    assign o_status.slot_free  = w_slot_free;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= gnmc_pkg::CFG_W'(1);
            r_column_count <= gnmc_pkg::CFG_W'(1);
            r_clr_addr     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gnmc_pkg::CFG_ROW_COUNT:    r_row_count    <= i_cfg_data;
                    gnmc_pkg::CFG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_ctrl.clear_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_ctrl.emit_hit || i_ctrl.emit_none) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.query_load) begin
            r_cell    <= i_cell_index;
            r_quo     <= i_cell_index;
            r_rem     <= '0;
            r_div_cnt <= '0;
            r_tiles   <= '0;
            r_mines   <= '0;
        end
        if (i_ctrl.div_step) begin
            r_div_cnt <= r_div_cnt + 1'b1;
            r_quo     <= {r_quo[CW-2:0], w_div_fit};
            r_rem     <= w_div_fit ? gnmc_pkg::CFG_W'(w_div_trial - w_cc)
                                   : w_div_trial[gnmc_pkg::CFG_W-1:0];
        end
        if (i_ctrl.mask_load) begin
            r_mask <= w_mask;
            r_k    <= '0;
        end
        if (i_ctrl.k_skip) begin
            r_k <= r_k + 1'b1;
        end
        if (i_ctrl.read_issue) begin
            r_nbr_idx     <= w_idx[CW-1:0];
            r_rd_in_range <= (32'(w_idx) < 32'(MAX_CELLS));
            r_rd_last     <= (w_above == '0);
        end
        if (i_ctrl.emit_hit) begin
            r_k          <= r_k + 1'b1;
            r_tiles      <= r_tiles + 1'b1;
            r_mines      <= r_mines + TW'(w_mark);
            r_out_index  <= r_nbr_idx;
            r_out_marked <= w_mark;
            r_out_has    <= 1'b1;
            r_out_tiles  <= r_tiles + 1'b1;
            r_out_mines  <= r_mines + TW'(w_mark);
            r_out_last   <= r_rd_last;
        end
        if (i_ctrl.emit_none) begin
            r_out_index  <= '0;
            r_out_marked <= 1'b0;
            r_out_has    <= 1'b0;
            r_out_tiles  <= '0;
            r_out_mines  <= '0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_neighbor_index  = r_out_index;
    assign o_neighbor_marked = r_out_marked;
    assign o_has_neighbor    = r_out_has;
    assign o_tile_count      = r_out_tiles;
    assign o_mine_count      = r_out_mines;
    assign o_last            = r_out_last;

endmodule

@@ hdl/grid_neighbor_mine_count.sv @@
// ----------------------------------------------------------------------------
// grid_neighbor_mine_count
// Per-cell mark store of a configurable grid with 8-connected neighbour
// queries giving running neighbour and marked-neighbour counts.
// ----------------------------------------------------------------------------
// Write word: written to the mark store, no result.
// Query word: accepted, then divided (one quotient bit a cycle) into row and
//   column, the neighbour mask is loaded, out-of-grid positions are skipped
//   and each in-grid neighbour is read from the mark store and emitted.
// One word is in flight at a time; a result waits in the output register.
// Reset: synchronous, active low; the mark store is then cleared one entry a
//   cycle, all MAX_CELLS entries, with input held off and config still taken.
module grid_neighbor_mine_count #(
    parameter int MAX_CELLS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [gnmc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gnmc_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_cmd,
    input  logic [gnmc_pkg::CELL_W-1:0]          i_cell_index,
    input  logic                                 i_mark_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [gnmc_pkg::CELL_W-1:0]          o_neighbor_index,
    output logic                                 o_neighbor_marked,
    output logic                                 o_has_neighbor,
    output logic [gnmc_pkg::TALLY_W-1:0]         o_tile_count,
    output logic [gnmc_pkg::TALLY_W-1:0]         o_mine_count,
    output logic                                 o_last
);

    gnmc_pkg::t_ctrl_cmd  w_ctrl;
    gnmc_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    gnmc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_cmd     (i_cmd),
        .o_in_ready(o_in_ready),
        .i_status  (w_status),
        .o_ctrl    (w_ctrl)
    );

    gnmc_dp #(
        .MAX_CELLS(MAX_CELLS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cell_index     (i_cell_index),
        .i_mark_value     (i_mark_value),
        .i_out_ready      (i_out_ready),
        .i_ctrl           (w_ctrl),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .o_neighbor_index (o_neighbor_index),
        .o_neighbor_marked(o_neighbor_marked),
        .o_has_neighbor   (o_has_neighbor),
        .o_tile_count     (o_tile_count),
        .o_mine_count     (o_mine_count),
        .o_last           (o_last)
    );

endmodule

@@ hdl/gnmc_checker.sv @@
// ----------------------------------------------------------------------------
// gnmc_checker
// Port-level checks of the result channel of grid_neighbor_mine_count.
// ----------------------------------------------------------------------------
module gnmc_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    input  logic [gnmc_pkg::CELL_W-1:0]          o_neighbor_index,
    input  logic                                 o_neighbor_marked,
    input  logic                                 o_has_neighbor,
    input  logic [gnmc_pkg::TALLY_W-1:0]         o_tile_count,
    input  logic [gnmc_pkg::TALLY_W-1:0]         o_mine_count,
    input  logic                                 o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_neighbor_index) &&
            $stable(o_tile_count) && $stable(o_last))
        else $error("result word changed while stalled");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_neighbor |-> o_last && !o_neighbor_marked &&
            (o_tile_count == '0) && (o_mine_count == '0))
        else $error("no-neighbor word malformed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_mine_count <= o_tile_count) &&
            (o_tile_count <= gnmc_pkg::TALLY_W'(gnmc_pkg::NBR_NUM)))
        else $error("counts out of range");

    a_hit_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_neighbor |-> (o_tile_count != '0) &&
            (!o_neighbor_marked || (o_mine_count != '0)))
        else $error("neighbor word counts inconsistent");

endmodule

bind grid_neighbor_mine_count gnmc_checker u_gnmc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_neighbor_index (o_neighbor_index),
    .o_neighbor_marked(o_neighbor_marked),
    .o_has_neighbor   (o_has_neighbor),
    .o_tile_count     (o_tile_count),
    .o_mine_count     (o_mine_count),
    .o_last           (o_last)
);
